@@ src/biquad_lowpass_filter_core_defines.svh @@
// Assertion macros shared by the biquad low-pass filter core.
// Under SYNTHESIS the macros expand to nothing.
`ifndef BIQUAD_LOWPASS_FILTER_CORE_DEFINES_SVH
`define BIQUAD_LOWPASS_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BQLP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BQLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BQLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define BQLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/bqlp_pkg.sv @@
// Types and constants shared by the biquad low-pass filter core.
// No dependencies.
package bqlp_pkg;

	localparam int COEF_W      = 18;
	localparam int B0_W        = 17;
	localparam int STATE_FRAC  = 14;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 18;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ENABLE = 2'd0,
		REG_B0     = 2'd1,
		REG_A1     = 2'd2,
		REG_A2     = 2'd3
	} bqlp_cfg_reg_t;

	typedef enum logic [1:0] {
		MSEL_LO,
		MSEL_HI,
		MSEL_Y
	} bqlp_mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_SUB_LO,
		ACC_SUB_HI,
		ACC_SUM_Y
	} bqlp_acc_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC_HI,
		ST_W_FORM,
		ST_SUM,
		ST_MUL_Y,
		ST_ACC_Y,
		ST_OUT
	} bqlp_state_t;

	typedef struct packed {
		logic          capture;
		logic          mul_en;
		bqlp_mul_sel_t mul_sel;
		bqlp_acc_op_t  acc_op;
		logic          w_en;
		logic          s_en;
		logic          out_en;
	} bqlp_cmd_t;

	typedef struct packed {
		logic enable;
	} bqlp_status_t;

endpackage

@@ src/bqlp_if.sv @@
// Valid/ready stream interfaces for the sample input and the filtered output.
// No dependencies.
interface bqlp_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface bqlp_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           guard_hit;

	modport source (output valid, output sample_out, output guard_hit, input ready);
	modport sink (input valid, input sample_out, input guard_hit, output ready);
endinterface

@@ src/biquad_lowpass_filter_core.sv @@
// Top level of the second-order low-pass biquad (direct form II).
// Depends on bqlp_pkg, bqlp_if, bqlp_ctrl and bqlp_datapath.
//
//   Channel    Direction  Payload                 Handshake
//   samples    in         sample_in               valid/ready
//   filtered   out        sample_out, guard_hit   valid/ready
//   cfg        in         cfg_index, cfg_data     cfg_wr_en, no wait
//
// A filtered sample passes the steps MUL_LO, MUL_HI, ACC_HI, W_FORM, SUM, MUL_Y, ACC_Y
// and OUT before it reaches the output register; the two shared multiplier lanes form the
// feedback and feedforward sums in halves. With the filter disabled a sample goes from
// acceptance straight to the output step. One sample is in work at a time; the next is
// accepted the cycle after the result is registered. A finished sample waits in the output
// step while the previous result is still blocked.
// Reset clears the configuration, the delay line and the output valid flag.
module biquad_lowpass_filter_core
	import bqlp_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 16,
	parameter int STATE_WIDTH    = 40
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	bqlp_in_if.sink                samples,
	bqlp_out_if.source             filtered
);

	bqlp_cmd_t    cmd;
	bqlp_status_t status;

	bqlp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (filtered.valid),
		.out_ready (filtered.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bqlp_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.STATE_WIDTH    (STATE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (samples.sample_in),
		.cmd        (cmd),
		.status     (status),
		.sample_out (filtered.sample_out),
		.guard_hit  (filtered.guard_hit)
	);

endmodule

@@ src/bqlp_ctrl.sv @@
// Sequencing state machine of the biquad core and the output valid flag.
// Depends on bqlp_pkg and biquad_lowpass_filter_core_defines.svh.
`include "biquad_lowpass_filter_core_defines.svh"

module bqlp_ctrl
	import bqlp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  bqlp_status_t status,
	output bqlp_cmd_t    cmd
);

	bqlp_state_t state_q;
	bqlp_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MSEL_LO;
		cmd.acc_op  = ACC_HOLD;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = status.enable ? ST_MUL_LO : ST_OUT;
				end
			end
			ST_MUL_LO: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_HI;
				cmd.acc_op  = ACC_SUB_LO;
				state_d     = ST_ACC_HI;
			end
			ST_ACC_HI: begin
				cmd.acc_op = ACC_SUB_HI;
				state_d    = ST_W_FORM;
			end
			ST_W_FORM: begin
				cmd.w_en = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.s_en = 1'b1;
				state_d  = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_Y;
				state_d     = ST_ACC_Y;
			end
			ST_ACC_Y: begin
				cmd.acc_op = ACC_SUM_Y;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`BQLP_ASSERT(a_result_from_out, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_OUT), "result raised outside the output step")
	`BQLP_ASSERT_NEXT(a_out_stall, clk, arst_n, state_q == ST_OUT && out_valid_q && !out_ready, state_q == ST_OUT && out_valid_q, "output step left while the result was blocked")
	`BQLP_ASSERT_NEXT(a_bypass_path, clk, arst_n, in_valid && in_ready && !status.enable, state_q == ST_OUT, "disabled transaction did not go straight to output")

endmodule

@@ src/bqlp_datapath.sv @@
// Datapath of the biquad core: configuration registers, delay line, two
// shared multiplier lanes, accumulator and the rounding and saturation logic.
// Depends on bqlp_pkg.
module bqlp_datapath
	import bqlp_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 16,
	parameter int STATE_WIDTH    = 40
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  bqlp_cmd_t                      cmd,
	output bqlp_status_t                   status,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           guard_hit
);

	localparam int LO_W   = STATE_WIDTH / 2;
	localparam int HI_W   = STATE_WIDTH - LO_W;
	localparam int S_W    = STATE_WIDTH + 2;
	localparam int MB_W   = S_W - LO_W;
	localparam int PROD_W = COEF_W + MB_W;
	localparam int X_SH   = STATE_FRAC + COEF_FRAC_BITS;
	localparam int ACC_A  = STATE_WIDTH + COEF_W + 3;
	localparam int ACC_B  = SAMPLE_WIDTH + X_SH + 3;
	localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam int XS_A   = SAMPLE_WIDTH + STATE_FRAC;
	localparam int XS_W   = (XS_A > STATE_WIDTH) ? XS_A : STATE_WIDTH;

	localparam logic signed [ACC_W-1:0] W_HALF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] Y_HALF =
		{{(ACC_W-1){1'b0}}, 1'b1} << (X_SH - 1);
	localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
	localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic                          enable_q;
	logic [B0_W-1:0]               coef_b0_q;
	logic signed [COEF_W-1:0]      coef_a1_q;
	logic signed [COEF_W-1:0]      coef_a2_q;
	logic signed [STATE_WIDTH-1:0] d1_q;
	logic signed [STATE_WIDTH-1:0] d2_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [PROD_W-1:0]      prod_a_q;
	logic signed [PROD_W-1:0]      prod_b_q;
	logic signed [STATE_WIDTH-1:0] w_q;
	logic                          guard_q;
	logic signed [S_W-1:0]         s_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                          guard_out_q;

	logic signed [COEF_W-1:0]      b0_ext;
	logic signed [COEF_W-1:0]      coef_a;
	logic signed [COEF_W-1:0]      coef_b;
	logic signed [MB_W-1:0]        data_a;
	logic signed [MB_W-1:0]        data_b;
	logic signed [ACC_W-1:0]       x_ext;
	logic signed [ACC_W-1:0]       pa_ext;
	logic signed [ACC_W-1:0]       pb_ext;
	logic signed [ACC_W-1:0]       psum_sh;
	logic signed [ACC_W-1:0]       pb_sh;
	logic signed [ACC_W-1:0]       w_round;
	logic                          w_fits;
	logic signed [XS_W-1:0]        xs;
	logic                          xs_fits;
	logic signed [STATE_WIDTH-1:0] xs_sat;
	logic signed [S_W-1:0]         s_sum;
	logic signed [ACC_W-1:0]       y_round;
	logic                          y_fits;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			coef_b0_q <= '0;
			coef_a1_q <= '0;
			coef_a2_q <= '0;
		end else if (cfg_wr_en) begin
			case (bqlp_cfg_reg_t'(cfg_index))
				REG_ENABLE: enable_q  <= cfg_data[0];
				REG_B0:     coef_b0_q <= cfg_data[B0_W-1:0];
				REG_A1:     coef_a1_q <= cfg_data[COEF_W-1:0];
				REG_A2:     coef_a2_q <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign b0_ext = {1'b0, coef_b0_q};

	always_comb begin
		case (cmd.mul_sel)
			MSEL_HI: begin
				coef_a = coef_a1_q;
				coef_b = coef_a2_q;
				data_a = {{(MB_W-HI_W){d1_q[STATE_WIDTH-1]}}, d1_q[STATE_WIDTH-1:LO_W]};
				data_b = {{(MB_W-HI_W){d2_q[STATE_WIDTH-1]}}, d2_q[STATE_WIDTH-1:LO_W]};
			end
			MSEL_Y: begin
				coef_a = b0_ext;
				coef_b = b0_ext;
				data_a = {{(MB_W-LO_W){1'b0}}, s_q[LO_W-1:0]};
				data_b = s_q[S_W-1:LO_W];
			end
			default: begin
				coef_a = coef_a1_q;
				coef_b = coef_a2_q;
				data_a = {{(MB_W-LO_W){1'b0}}, d1_q[LO_W-1:0]};
				data_b = {{(MB_W-LO_W){1'b0}}, d2_q[LO_W-1:0]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_a_q <= coef_a * data_a;
			prod_b_q <= coef_b * data_b;
		end
	end

	assign x_ext   = {{(ACC_W-SAMPLE_WIDTH){sample_in[SAMPLE_WIDTH-1]}}, sample_in} <<< X_SH;
	assign pa_ext  = {{(ACC_W-PROD_W){prod_a_q[PROD_W-1]}}, prod_a_q};
	assign pb_ext  = {{(ACC_W-PROD_W){prod_b_q[PROD_W-1]}}, prod_b_q};
	assign psum_sh = (pa_ext + pb_ext) <<< LO_W;
	assign pb_sh   = pb_ext <<< LO_W;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q   <= sample_in;
			acc_q <= x_ext;
		end else begin
			case (cmd.acc_op)
				ACC_SUB_LO: acc_q <= acc_q - pa_ext - pb_ext;
				ACC_SUB_HI: acc_q <= acc_q - psum_sh;
				ACC_SUM_Y:  acc_q <= pa_ext + pb_sh;
				default: begin
				end
			endcase
		end
	end

	// New delay value, rounded half up; on overflow the sample replaces it.
	assign w_round = (acc_q + W_HALF) >>> COEF_FRAC_BITS;
	assign w_fits  = (w_round[ACC_W-1:STATE_WIDTH-1] == '0) ||
		(w_round[ACC_W-1:STATE_WIDTH-1] == '1);
	assign xs      = {{(XS_W-SAMPLE_WIDTH){x_q[SAMPLE_WIDTH-1]}}, x_q} <<< STATE_FRAC;
	assign xs_fits = (xs[XS_W-1:STATE_WIDTH-1] == '0) || (xs[XS_W-1:STATE_WIDTH-1] == '1);
	assign xs_sat  = xs_fits ? xs[STATE_WIDTH-1:0] : (xs[XS_W-1] ? ST_MIN : ST_MAX);

	always_ff @(posedge clk) begin
		if (cmd.w_en) begin
			w_q     <= w_fits ? w_round[STATE_WIDTH-1:0] : xs_sat;
			guard_q <= !w_fits;
		end
	end

	assign s_sum = {{2{w_q[STATE_WIDTH-1]}}, w_q}
		+ {d1_q[STATE_WIDTH-1], d1_q, 1'b0}
		+ {{2{d2_q[STATE_WIDTH-1]}}, d2_q};

	always_ff @(posedge clk) begin
		if (cmd.s_en) begin
			s_q <= s_sum;
		end
	end

	assign y_round = (acc_q + Y_HALF) >>> X_SH;
	assign y_fits  = (y_round[ACC_W-1:SAMPLE_WIDTH-1] == '0) ||
		(y_round[ACC_W-1:SAMPLE_WIDTH-1] == '1);
	assign y_sat   = y_fits ? y_round[SAMPLE_WIDTH-1:0] : (y_round[ACC_W-1] ? SMP_MIN : SMP_MAX);

	always_ff @(posedge clk) begin
		if (cmd.out_en) begin
			if (enable_q) begin
				sample_out_q <= y_sat;
				guard_out_q  <= guard_q;
			end else begin
				sample_out_q <= x_q;
				guard_out_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (cmd.out_en && enable_q) begin
			d2_q <= d1_q;
			d1_q <= w_q;
		end
	end

	assign status.enable = enable_q;
	assign sample_out    = sample_out_q;
	assign guard_hit     = guard_out_q;

endmodule
